### rtl/cbe_pkg.sv
// Shared types and byte constants for the control byte escape codec.
package cbe_pkg;

    localparam logic [7:0] CH_ESC    = 8'h21;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] HI_LOW    = 8'h80;
    localparam logic [7:0] HI_END    = 8'hA0;
    localparam logic [7:0] LOW7      = 8'h7F;
    localparam logic [7:0] SHIFT_OFS = 8'h40;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       bad_escape;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        logic       next_escape;
    } t_map;

endpackage

### rtl/cbe_map.sv
// Combinational byte mapping for one input byte in either direction.
module cbe_map (
    input  logic          i_direction,
    input  logic          i_escape,
    input  logic [7:0]    i_byte,
    input  logic          i_first,
    output cbe_pkg::t_map o_map
);
    import cbe_pkg::*;

    logic esc;
    logic in_high;

    assign esc     = i_escape & ~i_first;
    assign in_high = (i_byte >= HI_LOW) && (i_byte < HI_END);

    always_comb begin
        o_map             = '0;
        o_map.count       = 2'd1;
        o_map.res0        = '{out_byte: i_byte, is_last: 1'b1, bad_escape: 1'b0};
        o_map.res1        = '{out_byte: i_byte, is_last: 1'b1, bad_escape: 1'b0};
        o_map.next_escape = esc;
        if (i_direction == DIR_ENCODE) begin
            if (i_byte < CH_SPACE) begin
                o_map.res0.out_byte = i_byte + HI_LOW;
            end else if (in_high || i_byte == CH_ESC) begin
                // Two bytes: the escape mark first, then the shifted byte (or a second escape mark).
                o_map.count         = 2'd2;
                o_map.res0.out_byte = CH_ESC;
                o_map.res0.is_last  = 1'b0;
                o_map.res1.out_byte = in_high ? (i_byte - SHIFT_OFS) : CH_ESC;
            end
        end else begin
            if (esc) begin
                o_map.next_escape = 1'b0;
                if (i_byte == CH_ESC) begin
                    o_map.res0.out_byte = CH_ESC;
                end else if (i_byte >= CH_AT && i_byte <= CH_UNDER) begin
                    o_map.res0.out_byte = i_byte + SHIFT_OFS;
                end else begin
                    o_map.res0.out_byte   = 8'h00;
                    o_map.res0.bad_escape = 1'b1;
                end
            end else if (in_high) begin
                o_map.res0.out_byte = i_byte & LOW7;
            end else if (i_byte == CH_ESC) begin
                // A lone escape mark produces no output.
                o_map.count       = 2'd0;
                o_map.next_escape = 1'b1;
            end
        end
    end

endmodule

### rtl/control_byte_escape_codec_unit.sv
// Top level of the control byte escape codec: input stage, mapper, result stage.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = data_byte, tuser = first
//  m_axis    out        tdata = out_byte, tlast = is_last, tuser = bad_escape
//  cfg       in         i_cfg_data = direction (0 decode, 1 encode)
//
// Each byte moves from the input register through the mapper to the result register.
// One byte per cycle while m_axis is ready and each byte gives at most one result;
// an encoded byte that gives two results holds the result register, and so the
// input, until its second result is taken.
// Reset clears the valid flags, the escape flag and the direction (decode).
// A stall on m_axis backs up into s_axis through the input register.
module control_byte_escape_codec_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] first
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser,   // [0] bad_escape
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import cbe_pkg::*;

    logic       r_dir, n_dir;
    logic       r_esc, n_esc;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte, n_in_byte;
    logic       r_in_first, n_in_first;
    logic [1:0] r_cnt, n_cnt;
    t_result    r_res0, n_res0;
    t_result    r_res1, n_res1;

    t_map       map;
    logic       take;
    logic       space;
    logic       adv;
    logic       in_acc;

    cbe_map u_map (
        .i_direction (r_dir),
        .i_escape    (r_esc),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .o_map       (map)
    );

    assign take   = (r_cnt != 2'd0) && m_axis_tready;
    assign space  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign adv    = r_in_valid && space;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !r_in_valid || space;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_res0.out_byte;
    assign m_axis_tlast  = r_res0.is_last;
    assign m_axis_tuser  = r_res0.bad_escape;

    always_comb begin
        n_dir      = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_dir;
        n_esc      = adv ? map.next_escape : r_esc;
        n_in_valid = in_acc ? 1'b1 : (adv ? 1'b0 : r_in_valid);
        n_in_byte  = in_acc ? s_axis_tdata : r_in_byte;
        n_in_first = in_acc ? s_axis_tuser : r_in_first;
        n_cnt      = r_cnt;
        n_res0     = r_res0;
        n_res1     = r_res1;
        if (adv) begin
            n_cnt  = map.count;
            n_res0 = map.res0;
            n_res1 = map.res1;
        end else if (take) begin
            // Second result of a pair moves up to the output slot.
            n_cnt  = r_cnt - 2'd1;
            n_res0 = r_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= DIR_DECODE;
            r_esc      <= 1'b0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_dir      <= n_dir;
            r_esc      <= n_esc;
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_in_first <= n_in_first;
        r_res0     <= n_res0;
        r_res1     <= n_res1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !m_axis_tlast)
        else $error("first of a result pair marked last");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'h00 && m_axis_tlast))
        else $error("bad escape result not zero or not last");

    a_esc_decode_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_esc) |-> $past(r_dir == DIR_DECODE))
        else $error("escape flag set in encode mode");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !space) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input stage lost a stalled byte");

endmodule
